// ----- src/text_console_writer_macros.svh -----
// Assertion helpers shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Condition must never hold outside reset.
`define TCW_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
package tcw_pkg;

  // Default geometry
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration registers
  localparam int            CFG_IDX_W        = 1;
  localparam int            CFG_DATA_W       = 5;
  localparam logic [0:0]    REG_FRAME_TOP    = 1'b0;
  localparam logic [0:0]    REG_FRAME_BOTTOM = 1'b1;
  localparam logic [4:0]    FRAME_TOP_RST    = 5'd0;
  localparam logic [4:0]    FRAME_BOTTOM_RST = 5'd25;

  // Function codes on the command channel
  localparam logic [3:0] FUNC_PUT_CHAR      = 4'd0;
  localparam logic [3:0] FUNC_GOTO          = 4'd1;
  localparam logic [3:0] FUNC_SET_COLOR     = 4'd2;
  localparam logic [3:0] FUNC_SAVE_BOTH     = 4'd3;
  localparam logic [3:0] FUNC_RESTORE_BOTH  = 4'd4;
  localparam logic [3:0] FUNC_SAVE_COLOR    = 4'd5;
  localparam logic [3:0] FUNC_RESTORE_COLOR = 4'd6;
  localparam logic [3:0] FUNC_CLEAR         = 4'd7;
  localparam logic [3:0] FUNC_READ_CELL     = 4'd8;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Classified operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP           = 4'd0;
  localparam op_t OP_PRINT         = 4'd1;
  localparam op_t OP_BS            = 4'd2;
  localparam op_t OP_NL            = 4'd3;
  localparam op_t OP_TAB           = 4'd4;
  localparam op_t OP_GOTO          = 4'd5;
  localparam op_t OP_COLOR         = 4'd6;
  localparam op_t OP_SAVE_ALL      = 4'd7;
  localparam op_t OP_RESTORE_ALL   = 4'd8;
  localparam op_t OP_SAVE_COLOR    = 4'd9;
  localparam op_t OP_RESTORE_COLOR = 4'd10;
  localparam op_t OP_CLEAR         = 4'd11;
  localparam op_t OP_READ          = 4'd12;

  // One classified command
  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;       // character to write and report
    logic [6:0]  col;      // clamped goto column
    logic [4:0]  row;      // clamped goto row
    logic [7:0]  color;    // bg << 4 | fg
    logic [10:0] addr;     // read address
    logic        addr_ok;  // read address inside the screen
  } cmd_t;

  // Effective scrolling frame, top row and exclusive bottom row
  typedef struct packed {
    logic [4:0] top;
    logic [4:0] bot;
  } frame_t;

endpackage

// ----- src/tcw_front.sv -----
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  logic [3:0]    func,
  input  logic [7:0]    char_code,
  input  logic [6:0]    col_x,
  input  logic [4:0]    row_y,
  input  logic [3:0]    fg_color,
  input  logic [3:0]    bg_color,
  input  logic [10:0]   cell_addr,
  input  logic          q_full,
  output logic          q_push,
  output tcw_pkg::cmd_t q_cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  logic          f_valid;
  tcw_pkg::cmd_t f_cmd;
  tcw_pkg::cmd_t cls;

  // Classify the incoming item
  always_comb begin
    cls         = '0;
    cls.color   = {bg_color, fg_color};
    cls.col     = (32'(col_x) > 32'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : col_x;
    cls.row     = (32'(row_y) > 32'(ROWS - 1)) ? 5'(ROWS - 1) : row_y;
    cls.addr    = cell_addr;
    cls.addr_ok = 32'(cell_addr) < 32'(CELLS);
    unique case (func)
      tcw_pkg::FUNC_PUT_CHAR: begin
        cls.ch = char_code;
        unique case (char_code)
          tcw_pkg::CH_BS: begin
            cls.op = tcw_pkg::OP_BS;
            cls.ch = tcw_pkg::CH_SPACE;
          end
          tcw_pkg::CH_LF, tcw_pkg::CH_CR: cls.op = tcw_pkg::OP_NL;
          tcw_pkg::CH_TAB: cls.op = tcw_pkg::OP_TAB;
          default: cls.op = tcw_pkg::OP_PRINT;
        endcase
      end
      tcw_pkg::FUNC_GOTO:          cls.op = tcw_pkg::OP_GOTO;
      tcw_pkg::FUNC_SET_COLOR:     cls.op = tcw_pkg::OP_COLOR;
      tcw_pkg::FUNC_SAVE_BOTH:     cls.op = tcw_pkg::OP_SAVE_ALL;
      tcw_pkg::FUNC_RESTORE_BOTH:  cls.op = tcw_pkg::OP_RESTORE_ALL;
      tcw_pkg::FUNC_SAVE_COLOR:    cls.op = tcw_pkg::OP_SAVE_COLOR;
      tcw_pkg::FUNC_RESTORE_COLOR: cls.op = tcw_pkg::OP_RESTORE_COLOR;
      tcw_pkg::FUNC_CLEAR:         cls.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::FUNC_READ_CELL:     cls.op = tcw_pkg::OP_READ;
      default:                     cls.op = tcw_pkg::OP_NOP;
    endcase
  end

  // Holding register in front of the queue
  assign cmd_stall = f_valid && q_full;
  assign q_push    = f_valid && !q_full;
  assign q_cmd     = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!cmd_stall) begin
      f_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      f_cmd <= cls;
    end
  end

endmodule

// ----- src/tcw_queue.sv -----
`include "text_console_writer_macros.svh"

module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output tcw_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `TCW_ASSERT_NEVER(a_q_count, clk, rst, count > CNT_W'(DEPTH), "queue count beyond depth")
  `TCW_ASSERT_IMPL(a_q_push_full, clk, rst, push, !full, "transfer into a full queue")
  `TCW_ASSERT_IMPL(a_q_pop_empty, clk, rst, pop, count != '0, "pop from an empty queue")

endmodule

// ----- src/tcw_back.sv -----
`include "text_console_writer_macros.svh"

module tcw_back #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  tcw_pkg::frame_t frame,
  input  logic            q_valid,
  input  tcw_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output logic [7:0]      char_out,
  output logic [15:0]     cell_data,
  output logic [10:0]     cursor_pos,
  output logic            scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 2);
  localparam int RTW   = (RW > 5) ? RW : 5;
  localparam int SW    = $clog2(COLUMNS + TAB_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Control and cursor state
  logic [2:0]    state, state_next;
  logic [RW-1:0] cur_row, row_next;
  logic [CW-1:0] cur_col, col_next;
  logic [AW-1:0] cur_idx, idx_next;
  logic [7:0]    attr, attr_next;
  logic [RW-1:0] sv_row, sv_row_next;
  logic [CW-1:0] sv_col, sv_col_next;
  logic [AW-1:0] sv_idx, sv_idx_next;
  logic [7:0]    sv_color, sv_color_next;
  logic          pend_valid, pend_valid_next;

  // Per-command working registers
  tcw_pkg::op_t   op_r, op_next;
  logic [7:0]     ch_r, ch_next;
  logic           scr_r, scr_next;
  logic           rd_ok_r, rd_ok_next;
  logic [RTW-1:0] lines, lines_next;
  logic [PW-1:0]  src, src_next;
  logic [PW-1:0]  endp, endp_next;
  logic [PW-1:0]  shift, shift_next;
  logic [PW-1:0]  ptr, ptr_next;
  logic [AW-1:0]  pend_dst, pend_dst_next;

  // Cell store ports
  logic [15:0]   mem [CELLS];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  // Move decode
  logic           is_move;
  logic           move_hit;
  logic [RW-1:0]  tr;
  logic [CW-1:0]  tc;
  logic [AW-1:0]  idx_mv;
  logic [AW-1:0]  idx_ls;
  logic [SW-1:0]  tab_sum;
  logic [RTW-1:0] lines_raw;
  logic [RTW-1:0] height;
  logic [RTW-1:0] lines_clamp;

  // Output staging
  logic        out_free;
  logic        out_load;
  logic [7:0]  out_char;
  logic [15:0] out_cell;
  logic        out_scr;

  assign out_free = !rsp_valid || !rsp_stall;
  assign idx_ls   = cur_idx - AW'(cur_col);
  assign tab_sum  = SW'(cur_col) + SW'(TAB_WIDTH);

  // Target of a cursor move and whether it runs past the frame
  always_comb begin
    is_move = 1'b0;
    tr      = cur_row;
    tc      = cur_col;
    idx_mv  = cur_idx;
    unique case (q_cmd.op)
      tcw_pkg::OP_PRINT: begin
        is_move = 1'b1;
        idx_mv  = cur_idx + AW'(1);
        if (cur_col == CW'(COLUMNS - 1)) begin
          tr = cur_row + RW'(1);
          tc = '0;
        end else begin
          tc = cur_col + CW'(1);
        end
      end
      tcw_pkg::OP_NL: begin
        is_move = 1'b1;
        tr      = cur_row + RW'(1);
        tc      = '0;
        idx_mv  = AW'(32'(cur_idx) + 32'(COLUMNS) - 32'(cur_col));
      end
      tcw_pkg::OP_TAB: begin
        is_move = 1'b1;
        idx_mv  = AW'(32'(cur_idx) + 32'(TAB_WIDTH));
        if (32'(tab_sum) >= 32'(2 * COLUMNS)) begin
          tr = cur_row + RW'(2);
          tc = CW'(32'(tab_sum) - 32'(2 * COLUMNS));
        end else if (32'(tab_sum) >= 32'(COLUMNS)) begin
          tr = cur_row + RW'(1);
          tc = CW'(32'(tab_sum) - 32'(COLUMNS));
        end else begin
          tc = CW'(tab_sum);
        end
      end
      tcw_pkg::OP_BS: begin
        is_move = 1'b1;
        if (cur_col != '0) begin
          tc     = cur_col - CW'(1);
          idx_mv = cur_idx - AW'(1);
        end else if (cur_row != '0) begin
          tr     = cur_row - RW'(1);
          tc     = CW'(COLUMNS - 1);
          idx_mv = cur_idx - AW'(1);
        end else begin
          idx_mv = '0;
        end
      end
      default: begin
        is_move = 1'b0;
      end
    endcase
    move_hit    = is_move && (RTW'(tr) >= RTW'(frame.bot));
    lines_raw   = RTW'(tr) - RTW'(frame.bot) + RTW'(1);
    height      = RTW'(frame.bot - frame.top);
    lines_clamp = (lines_raw > height) ? height : lines_raw;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    row_next        = cur_row;
    col_next        = cur_col;
    idx_next        = cur_idx;
    attr_next       = attr;
    sv_row_next     = sv_row;
    sv_col_next     = sv_col;
    sv_idx_next     = sv_idx;
    sv_color_next   = sv_color;
    pend_valid_next = 1'b0;
    op_next         = op_r;
    ch_next         = ch_r;
    scr_next        = scr_r;
    rd_ok_next      = rd_ok_r;
    lines_next      = lines;
    src_next        = src;
    endp_next       = endp;
    shift_next      = shift;
    ptr_next        = ptr;
    pend_dst_next   = pend_dst;
    wr_en           = 1'b0;
    wr_addr         = cur_idx;
    wr_data         = {attr, tcw_pkg::CH_SPACE};
    rd_en           = 1'b0;
    rd_addr         = src[AW-1:0];
    q_pop           = 1'b0;
    out_load        = 1'b0;
    out_char        = 8'd0;
    out_cell        = 16'd0;
    out_scr         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop      = 1'b1;
          op_next    = q_cmd.op;
          ch_next    = q_cmd.ch;
          scr_next   = move_hit;
          rd_ok_next = q_cmd.addr_ok;
          lines_next = lines_clamp;
          unique case (q_cmd.op)
            tcw_pkg::OP_PRINT, tcw_pkg::OP_BS, tcw_pkg::OP_NL, tcw_pkg::OP_TAB: begin
              // printable lands at the old cursor before any scroll
              if (q_cmd.op == tcw_pkg::OP_PRINT) begin
                wr_en   = 1'b1;
                wr_addr = cur_idx;
                wr_data = {attr, q_cmd.ch};
              end
              if (move_hit) begin
                col_next   = '0;
                idx_next   = idx_ls;
                state_next = ST_SETUP;
              end else begin
                row_next = tr;
                col_next = tc;
                idx_next = idx_mv;
                out_load = 1'b1;
                out_char = q_cmd.ch;
                if (q_cmd.op == tcw_pkg::OP_BS) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_mv;
                end
              end
            end
            tcw_pkg::OP_GOTO: begin
              row_next = RW'(q_cmd.row);
              col_next = CW'(q_cmd.col);
              idx_next = AW'(32'(q_cmd.row) * 32'(COLUMNS) + 32'(q_cmd.col));
              out_load = 1'b1;
            end
            tcw_pkg::OP_COLOR: begin
              attr_next = q_cmd.color;
              out_load  = 1'b1;
            end
            tcw_pkg::OP_SAVE_ALL: begin
              sv_row_next   = cur_row;
              sv_col_next   = cur_col;
              sv_idx_next   = cur_idx;
              sv_color_next = attr;
              out_load      = 1'b1;
            end
            tcw_pkg::OP_RESTORE_ALL: begin
              row_next  = sv_row;
              col_next  = sv_col;
              idx_next  = sv_idx;
              attr_next = sv_color;
              out_load  = 1'b1;
            end
            tcw_pkg::OP_SAVE_COLOR: begin
              sv_color_next = attr;
              out_load      = 1'b1;
            end
            tcw_pkg::OP_RESTORE_COLOR: begin
              attr_next = sv_color;
              out_load  = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              ptr_next   = '0;
              endp_next  = PW'(CELLS);
              state_next = ST_BLANK;
            end
            tcw_pkg::OP_READ: begin
              rd_en      = q_cmd.addr_ok;
              rd_addr    = AW'(q_cmd.addr);
              state_next = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // Frame bounds in cell units
      ST_SETUP: begin
        src_next   = PW'((32'(frame.top) + 32'(lines)) * 32'(COLUMNS));
        endp_next  = PW'(32'(frame.bot) * 32'(COLUMNS));
        shift_next = PW'(32'(lines) * 32'(COLUMNS));
        state_next = ST_COPY;
      end

      // Move rows up: read ahead, write the read cell in the following cycle
      ST_COPY: begin
        if (src < endp) begin
          rd_en           = 1'b1;
          rd_addr         = src[AW-1:0];
          src_next        = src + PW'(1);
          pend_valid_next = 1'b1;
          pend_dst_next   = AW'(src - shift);
        end
        if (pend_valid) begin
          wr_en   = 1'b1;
          wr_addr = pend_dst;
          wr_data = rd_data;
        end
        if (!(src < endp) && !pend_valid) begin
          ptr_next   = endp - shift;
          state_next = ST_BLANK;
        end
      end

      // Blank vacated rows, or the whole screen for clear
      ST_BLANK: begin
        if (ptr < endp) begin
          wr_en    = 1'b1;
          wr_addr  = ptr[AW-1:0];
          ptr_next = ptr + PW'(1);
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_cell   = rd_ok_r ? rd_data : 16'd0;
          state_next = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_char = ch_r;
          out_scr  = scr_r;
          // backspace blanks the line start after its scroll
          if (op_r == tcw_pkg::OP_BS) begin
            wr_en   = 1'b1;
            wr_addr = cur_idx;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_row    <= '0;
      cur_col    <= '0;
      cur_idx    <= '0;
      attr       <= '0;
      sv_row     <= '0;
      sv_col     <= '0;
      sv_idx     <= '0;
      sv_color   <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cur_row    <= row_next;
      cur_col    <= col_next;
      cur_idx    <= idx_next;
      attr       <= attr_next;
      sv_row     <= sv_row_next;
      sv_col     <= sv_col_next;
      sv_idx     <= sv_idx_next;
      sv_color   <= sv_color_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r     <= op_next;
    ch_r     <= ch_next;
    scr_r    <= scr_next;
    rd_ok_r  <= rd_ok_next;
    lines    <= lines_next;
    src      <= src_next;
    endp     <= endp_next;
    shift    <= shift_next;
    ptr      <= ptr_next;
    pend_dst <= pend_dst_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_out   <= out_char;
      cell_data  <= out_cell;
      cursor_pos <= 11'(idx_next);
      scrolled   <= out_scr;
    end
  end

  `TCW_ASSERT_NEVER(a_col_range, clk, rst, 32'(cur_col) >= 32'(COLUMNS), "cursor column out of range")
  `TCW_ASSERT_NEVER(a_row_range, clk, rst, 32'(cur_row) >= 32'(ROWS), "cursor row out of range")
  `TCW_ASSERT_NEVER(a_idx_match, clk, rst, 32'(cur_idx) != 32'(cur_row) * 32'(COLUMNS) + 32'(cur_col), "cursor index disagrees with row and column")
  `TCW_ASSERT_IMPL(a_pend_copy, clk, rst, pend_valid, state == ST_COPY, "pending copy write outside the copy walk")

endmodule

// ----- src/text_console_writer.sv -----
// Character-cell text console with a scrolling frame.
// Command channel (cmd_valid / cmd_stall) carries one item per transfer: func
// selects put char, goto, set colour, save/restore, clear or read cell. Every
// item returns exactly one result on the response channel (rsp_valid /
// rsp_stall): the character written, the cell read, the cursor index and a
// scroll flag. The user must write the frame registers through cfg_write,
// cfg_index and cfg_data only while no item is in flight; the block does not
// enforce this. An item passes the front register, the queue and the execute
// unit into the result register; a cell read also passes a read state.
// Simple items sustain one per cycle through the execute unit while the
// receiver does not stall. A scroll holds the execute unit while it moves
// the frame rows up and blanks the vacated rows, one cell per cycle through
// the cell store; clear blanks all COLUMNS * ROWS cells. Meanwhile the front
// and the 2-entry queue keep accepting items until full. Reset clears
// cursor, colour and saved state and sets the frame to top 0 and bottom 25;
// cell contents are undefined until a clear, so issue a clear first.
// While the receiver stalls the result is held, no item leaves the queue, and
// cmd_stall rises once the queue and front register have filled.
module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  // command channel
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [3:0]                     func,
  input  logic [7:0]                     char_code,
  input  logic [6:0]                     col_x,
  input  logic [4:0]                     row_y,
  input  logic [3:0]                     fg_color,
  input  logic [3:0]                     bg_color,
  input  logic [10:0]                    cell_addr,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [7:0]                     char_out,
  output logic [15:0]                    cell_data,
  output logic [10:0]                    cursor_pos,
  output logic                           scrolled
);

  logic [4:0]      frame_top_row;
  logic [4:0]      frame_bottom_row;
  logic [4:0]      bot_eff;
  tcw_pkg::frame_t frame;

  logic            q_push;
  logic            q_full;
  tcw_pkg::cmd_t   push_cmd;
  logic            q_pop;
  logic            q_valid;
  tcw_pkg::cmd_t   q_cmd;

  // Frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_top_row    <= tcw_pkg::FRAME_TOP_RST;
      frame_bottom_row <= tcw_pkg::FRAME_BOTTOM_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcw_pkg::REG_FRAME_TOP:    frame_top_row    <= cfg_data;
        tcw_pkg::REG_FRAME_BOTTOM: frame_bottom_row <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame to the screen; top stays above the bottom
  always_comb begin
    if (frame_bottom_row == 5'd0) begin
      bot_eff = 5'd1;
    end else if (32'(frame_bottom_row) > 32'(ROWS)) begin
      bot_eff = 5'(ROWS);
    end else begin
      bot_eff = frame_bottom_row;
    end
    frame.bot = bot_eff;
    frame.top = (frame_top_row >= bot_eff) ? bot_eff - 5'd1 : frame_top_row;
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .char_code (char_code),
    .col_x     (col_x),
    .row_y     (row_y),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .cell_addr (cell_addr),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  tcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .char_out   (char_out),
    .cell_data  (cell_data),
    .cursor_pos (cursor_pos),
    .scrolled   (scrolled)
  );

endmodule
